/* src/tsc_pkg.sv */
package tsc_pkg;

  // counter width inside the scanner; results carry the low OUT_W bits
  localparam int POS_WIDTH = 32;
  localparam int OUT_W     = 32;

  // output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int TDATA_BITS = 2 + 6 * OUT_W;
  localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_CLOSE  = 3'd3,
    MODE_DIGITS = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_UNDEF  = 2'd0,
    KIND_PLUS   = 2'd1,
    KIND_SEMI   = 2'd2,
    KIND_DIGITS = 2'd3
  } kind_t;

  typedef struct packed {
    mode_t                mode;
    logic [POS_WIDTH-1:0] line;
    logic [POS_WIDTH-1:0] col;
    logic [POS_WIDTH-1:0] off;
    logic [POS_WIDTH-1:0] lstart;
    logic [POS_WIDTH-1:0] tok_line;
    logic [POS_WIDTH-1:0] tok_col;
    logic [POS_WIDTH-1:0] tok_off;
    logic [POS_WIDTH-1:0] tok_lstart;
  } scan_state_t;

  typedef struct packed {
    kind_t            kind;
    logic [OUT_W-1:0] start_line;
    logic [OUT_W-1:0] start_column;
    logic [OUT_W-1:0] start_offset;
    logic [OUT_W-1:0] start_line_offset;
    logic [OUT_W-1:0] end_column;
    logic [OUT_W-1:0] end_offset;
    logic             final_token;
  } tok_t;

  localparam scan_state_t SCAN_RESET = '{
    mode:       MODE_NORMAL,
    line:       POS_WIDTH'(1),
    col:        POS_WIDTH'(1),
    off:        '0,
    lstart:     '0,
    tok_line:   '0,
    tok_col:    '0,
    tok_off:    '0,
    tok_lstart: '0
  };

  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
    return (v == POS_MAX) ? v : v + POS_WIDTH'(1);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic scan_state_t move_on(input scan_state_t s, input logic nl);
    scan_state_t r;
    r = s;
    if (nl) begin
      r.line   = sat_inc(s.line);
      r.col    = '0;
      r.lstart = sat_inc(s.off);
    end
    r.col = sat_inc(r.col);
    r.off = sat_inc(s.off);
    return r;
  endfunction

endpackage

/* src/source_token_scanner_unit.sv */
// Output: a token's word is written into the output queue when the byte that closes
//   it is accepted (a token closes when the byte after it arrives).
// Throughput: one byte per cycle while s_tready is high; a final byte can yield two
//   words, which leave a four-entry output queue one per cycle while m_tready is 1.
// Reset (rst, synchronous): scanner back to line 1, column 1, offset 0, no held byte.
module source_token_scanner_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // text_byte
  input  logic                        s_tlast,   // end_of_text
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // token_kind[1:0], start_line, start_column, start_offset,
  // start_line_offset, end_column, end_offset (32 each), zero pad
  output logic [tsc_pkg::TDATA_W-1:0] m_tdata,
  output logic                        m_tlast    // final_token
);

  tsc_pkg::scan_state_t st;
  tsc_pkg::scan_state_t st0;
  tsc_pkg::scan_state_t st1;
  logic [7:0]           held_byte;
  logic                 held_valid;
  logic                 stop;
  logic                 acc;
  logic                 emit0;
  logic                 emit1;
  tsc_pkg::tok_t        tok0;
  tsc_pkg::tok_t        tok1;
  tsc_pkg::tok_t        q0;
  tsc_pkg::tok_t        q1;
  tsc_pkg::tok_t        head;
  logic [1:0]           push_n;

  assign acc  = s_tvalid & s_tready;
  assign stop = (s_tdata == 8'd0) | s_tlast;

  tsc_scan u_scan_held (
    .en      (held_valid),
    .st      (st),
    .h       (held_byte),
    .x       (s_tdata),
    .st_next (st0),
    .emit    (emit0),
    .tok     (tok0)
  );

  // last byte of the text (unless it is a NUL) is scanned by a second scanner with no successor
  tsc_scan u_scan_last (
    .en      (stop && s_tdata != 8'd0),
    .st      (st0),
    .h       (s_tdata),
    .x       (8'd0),
    .st_next (st1),
    .emit    (emit1),
    .tok     (tok1)
  );

  always_comb begin
    q0 = emit0 ? tok0 : tok1;
    q1 = tok1;
    q0.final_token = stop & ~(emit0 & emit1);
    q1.final_token = stop;
    push_n = acc ? (2'(emit0) + 2'(emit1)) : 2'd0;
  end

  tsc_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .in0        (q0),
    .in1        (q1),
    .pop_ready  (m_tready),
    .head       (head),
    .head_valid (m_tvalid),
    .room       (s_tready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= tsc_pkg::SCAN_RESET;
      held_byte  <= '0;
      held_valid <= 1'b0;
    end else if (acc) begin
      if (stop) begin
        st         <= tsc_pkg::SCAN_RESET;
        held_byte  <= '0;
        held_valid <= 1'b0;
      end else begin
        st         <= st1;
        held_byte  <= s_tdata;
        held_valid <= 1'b1;
      end
    end
  end

  assign m_tdata = tsc_pkg::TDATA_W'({head.end_offset, head.end_column,
                                      head.start_line_offset, head.start_offset,
                                      head.start_column, head.start_line, head.kind});
  assign m_tlast = head.final_token;

  a_stop_resets: assert property (@(posedge clk) disable iff (rst)
    (acc && stop) |=> (!held_valid && st.mode == tsc_pkg::MODE_NORMAL &&
                       st.line == tsc_pkg::POS_WIDTH'(1)))
    else $error("scanner not back at start after end of text");

  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (acc && !stop) |=> (held_valid && held_byte == $past(s_tdata)))
    else $error("lookahead byte not held");

endmodule

/* src/tsc_scan.sv */
// Scans one byte h with lookahead x; purely combinational.
module tsc_scan (
  input  logic                 en,
  input  tsc_pkg::scan_state_t st,
  input  logic [7:0]           h,
  input  logic [7:0]           x,
  output tsc_pkg::scan_state_t st_next,
  output logic                 emit,
  output tsc_pkg::tok_t        tok
);

  tsc_pkg::scan_state_t s;
  tsc_pkg::kind_t       kind;
  logic                 normal;
  logic                 emit_c;

  always_comb begin
    s      = st;
    normal = 1'b0;
    emit_c = 1'b0;
    kind   = tsc_pkg::KIND_UNDEF;

    unique case (st.mode)
      tsc_pkg::MODE_LINE: begin
        if (h != tsc_pkg::CH_LF) begin
          s = tsc_pkg::move_on(s, 1'b0);
        end else begin
          s.mode = tsc_pkg::MODE_NORMAL;
          normal = 1'b1;
        end
      end
      tsc_pkg::MODE_BLOCK: begin
        if (h == tsc_pkg::CH_STAR && x == tsc_pkg::CH_SLASH) begin
          s.mode = tsc_pkg::MODE_CLOSE;
        end
        s = tsc_pkg::move_on(s, 1'b0);
      end
      tsc_pkg::MODE_CLOSE: begin
        s.mode = tsc_pkg::MODE_NORMAL;
        s = tsc_pkg::move_on(s, 1'b0);
      end
      tsc_pkg::MODE_DIGITS: begin
        s = tsc_pkg::move_on(s, 1'b0);
        if (!tsc_pkg::is_digit(x)) begin
          s.mode = tsc_pkg::MODE_NORMAL;
          kind   = tsc_pkg::KIND_DIGITS;
          emit_c = 1'b1;
        end
      end
      default: begin
        s.mode = tsc_pkg::MODE_NORMAL;
        normal = 1'b1;
      end
    endcase

    if (normal) begin
      priority if (h == tsc_pkg::CH_SPACE || h == tsc_pkg::CH_TAB ||
                   h == tsc_pkg::CH_CR || h == tsc_pkg::CH_LF) begin
        s = tsc_pkg::move_on(s, h == tsc_pkg::CH_LF);
      end else if (h == tsc_pkg::CH_SLASH && x == tsc_pkg::CH_SLASH) begin
        s.mode = tsc_pkg::MODE_LINE;
        s = tsc_pkg::move_on(s, 1'b0);
      end else if (h == tsc_pkg::CH_SLASH && x == tsc_pkg::CH_STAR) begin
        s.mode = tsc_pkg::MODE_BLOCK;
        s = tsc_pkg::move_on(s, 1'b0);
      end else begin
        s.tok_line   = s.line;
        s.tok_col    = s.col;
        s.tok_off    = s.off;
        s.tok_lstart = s.lstart;
        if (tsc_pkg::is_digit(h) && tsc_pkg::is_digit(x)) begin
          s.mode = tsc_pkg::MODE_DIGITS;
        end else begin
          priority if (h == tsc_pkg::CH_PLUS) begin
            kind = tsc_pkg::KIND_PLUS;
          end else if (h == tsc_pkg::CH_SEMI) begin
            kind = tsc_pkg::KIND_SEMI;
          end else if (tsc_pkg::is_digit(h)) begin
            kind = tsc_pkg::KIND_DIGITS;
          end else begin
            kind = tsc_pkg::KIND_UNDEF;
          end
          emit_c = 1'b1;
        end
        s = tsc_pkg::move_on(s, 1'b0);
      end
    end
  end

  assign st_next = en ? s : st;
  assign emit    = en & emit_c;

  assign tok.kind              = kind;
  assign tok.start_line        = tsc_pkg::OUT_W'(s.tok_line);
  assign tok.start_column      = tsc_pkg::OUT_W'(s.tok_col);
  assign tok.start_offset      = tsc_pkg::OUT_W'(s.tok_off);
  assign tok.start_line_offset = tsc_pkg::OUT_W'(s.tok_lstart);
  assign tok.end_column        = tsc_pkg::OUT_W'(s.col);
  assign tok.end_offset        = tsc_pkg::OUT_W'(s.off);
  assign tok.final_token       = 1'b0;

endmodule

/* src/tsc_out_queue.sv */
// Small result queue: takes up to two words a cycle, hands out one.
module tsc_out_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_n,
  input  tsc_pkg::tok_t in0,
  input  tsc_pkg::tok_t in1,
  input  logic          pop_ready,
  output tsc_pkg::tok_t head,
  output logic          head_valid,
  output logic          room
);

  tsc_pkg::tok_t             mem [tsc_pkg::QDEPTH];
  logic [tsc_pkg::QPTR_W-1:0] wr;
  logic [tsc_pkg::QPTR_W-1:0] rd;
  logic [tsc_pkg::QCNT_W-1:0] count;
  logic                       pop;

  assign head_valid = (count != '0);
  assign pop        = head_valid & pop_ready;
  assign head       = mem[rd];
  // two free entries, so a final byte with two tokens always fits
  assign room       = (count <= tsc_pkg::QCNT_W'(tsc_pkg::QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr] <= in0;
    end
    if (push_n == 2'd2) begin
      mem[wr + tsc_pkg::QPTR_W'(1)] <= in1;
    end
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + tsc_pkg::QPTR_W'(push_n);
      rd    <= rd + tsc_pkg::QPTR_W'(pop);
      count <= count + tsc_pkg::QCNT_W'(push_n) - tsc_pkg::QCNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tsc_pkg::QCNT_W'(tsc_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0 && !pop) |=>
      count == $past(count) + tsc_pkg::QCNT_W'($past(push_n)))
    else $error("queue count lost a push");

endmodule
